// ===== src/tdq_pkg.sv =====
// Shared types and constants of the tick delay queue.
// No dependencies; imported by tdq_list, tick_delay_queue and the testbench.
package tdq_pkg;

  // Input word kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  // next_wake value when nothing waits
  localparam logic [31:0] NO_WAKE = 32'hFFFF_FFFF;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_TICK,
    ST_RELOAD,
    ST_CHECK,
    ST_POP_RD,
    ST_POP_CMP,
    ST_FINISH
  } state_t;

  // Commands to one ordered task list
  typedef enum logic [1:0] {
    LIST_NOP,
    LIST_DROP,
    LIST_INS
  } list_op_t;

endpackage

// ===== src/tdq_list.sv =====
// One ordered task list: entries shift left on a drop, right on an insert.
// Depends on tdq_pkg for the list command type.
module tdq_list #(
  parameter int MAX_TASKS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tdq_pkg::list_op_t                op,
  input  logic [$clog2(MAX_TASKS)-1:0]     pos,
  input  logic [$clog2(MAX_TASKS)-1:0]     id,
  input  logic [$clog2(MAX_TASKS)-1:0]     rd_idx,
  output logic [$clog2(MAX_TASKS)-1:0]     rd_id,
  output logic [$clog2(MAX_TASKS)-1:0]     head,
  output logic [$clog2(MAX_TASKS+1)-1:0]   count
);
  import tdq_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [IDX_W-1:0] entries [MAX_TASKS];

  assign rd_id = entries[rd_idx];
  assign head  = entries[0];

  // Track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op == LIST_DROP) begin
      count <= count - CNT_W'(1);
    end else if (op == LIST_INS) begin
      count <= count + CNT_W'(1);
    end
  end

  // Shift entries around the command position
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (op == LIST_DROP) begin
        if (j < MAX_TASKS - 1 && IDX_W'(j) >= pos) begin
          entries[j] <= entries[(j < MAX_TASKS - 1) ? j + 1 : j];
        end
      end else if (op == LIST_INS) begin
        if (IDX_W'(j) == pos) begin
          entries[j] <= id;
        end else if (j > 0 && IDX_W'(j) > pos) begin
          entries[j] <= entries[(j > 0) ? j - 1 : j];
        end
      end
    end
  end

endmodule

// ===== src/tick_delay_queue.sv =====
// Tick delay queue: a delay word keeps in_stall high after it is taken while the block
// searches both lists for the task, one list entry a cycle, then walks the target list in a
// sorted insert that reads and then compares one wake time per step over at most
// MAX_TASKS-1 queued tasks. A tick word passes through ST_TICK, ST_RELOAD on a counter
// wrap that brings in a non-empty list, ST_CHECK, a read and a compare state per popped
// task and ST_FINISH, and waits in ST_POP_CMP or ST_FINISH while out_stall holds a result.
// in_stall is high while a word is in work; one result word per woken task (or one empty
// result) leaves through a registered output, the final one marked by last.
module tick_delay_queue #(
  parameter int MAX_TASKS       = 16,
  parameter int PRIORITY_LEVELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [3:0]  task_id,
  input  logic [4:0]  task_prio,
  input  logic [31:0] delay_ticks,
  input  logic [4:0]  running_prio,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        woken_valid,
  output logic [3:0]  woken_task,
  output logic        switch_request,
  output logic        last
);
  import tdq_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // Control registers
  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [31:0]      tick_count, tick_count_next;
  logic [31:0]      next_wake, next_wake_next;
  logic             act_sel, act_sel_next;
  logic             time_slicing;
  logic             found0, found0_next, found1, found1_next;
  logic             sw, sw_next;
  logic             pend_v, pend_v_next;
  logic [IDX_W-1:0] pend_id, pend_id_next;

  // Payload registers
  logic [IDX_W-1:0] cur_id, cur_id_next;
  logic [31:0]      wake, wake_next;
  logic             ovf, ovf_next;
  logic [4:0]       run_prio, run_prio_next;

  // Wake time and priority memories
  logic [31:0]      wake_time   [MAX_TASKS];
  logic [4:0]       stored_prio [MAX_TASKS];
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      wt_q;
  logic [4:0]       pr_q;
  logic             mem_we;

  // Lists
  list_op_t         op0, op1;
  logic [IDX_W-1:0] l_pos, l_id;
  logic [IDX_W-1:0] rd0, rd1, head0, head1;
  logic [CNT_W-1:0] cnt0, cnt1;

  // Output stage
  logic             out_load;
  logic             o_valid_n, o_sw_n, o_last_n;
  logic [IDX_W-1:0] o_task_n;
  logic             out_free;

  // Accept-side helpers
  logic [32:0]      sum;
  logic             id_ok;
  logic [4:0]       prio_sat;

  // Active / overflow views
  logic [CNT_W-1:0] cnt_a, cnt_t;
  logic [IDX_W-1:0] head_a, rd_a, rd_o, rd_t;

  assign sum      = 33'(tick_count) + 33'(delay_ticks);
  assign id_ok    = 32'(task_id) < MAX_TASKS;
  assign prio_sat = (32'(task_prio) >= PRIORITY_LEVELS) ? 5'(PRIORITY_LEVELS - 1) : task_prio;

  assign cnt_a  = act_sel ? cnt1 : cnt0;
  assign head_a = act_sel ? head1 : head0;
  assign rd_a   = act_sel ? rd1 : rd0;
  assign rd_o   = act_sel ? rd0 : rd1;
  assign cnt_t  = ovf ? (act_sel ? cnt0 : cnt1) : cnt_a;
  assign rd_t   = ovf ? rd_o : rd_a;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  tdq_list #(.MAX_TASKS(MAX_TASKS)) u_list0 (
    .clk(clk), .rst(rst), .op(op0), .pos(l_pos), .id(l_id),
    .rd_idx(idx[IDX_W-1:0]), .rd_id(rd0), .head(head0), .count(cnt0)
  );

  tdq_list #(.MAX_TASKS(MAX_TASKS)) u_list1 (
    .clk(clk), .rst(rst), .op(op1), .pos(l_pos), .id(l_id),
    .rd_idx(idx[IDX_W-1:0]), .rd_id(rd1), .head(head1), .count(cnt1)
  );

  // Write on accepted delay, read one entry a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wake_time[IDX_W'(task_id)]   <= sum[31:0];
      stored_prio[IDX_W'(task_id)] <= prio_sat;
    end
    wt_q <= wake_time[rd_addr];
    pr_q <= stored_prio[rd_addr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_count   <= '0;
      next_wake    <= NO_WAKE;
      act_sel      <= 1'b0;
      time_slicing <= 1'b0;
    end else begin
      state      <= state_next;
      tick_count <= tick_count_next;
      next_wake  <= next_wake_next;
      act_sel    <= act_sel_next;
      if (cfg_we) begin
        time_slicing <= cfg_wdata;
      end
    end
    idx      <= idx_next;
    found0   <= found0_next;
    found1   <= found1_next;
    sw       <= sw_next;
    pend_v   <= pend_v_next;
    pend_id  <= pend_id_next;
    cur_id   <= cur_id_next;
    wake     <= wake_next;
    ovf      <= ovf_next;
    run_prio <= run_prio_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      woken_valid    <= o_valid_n;
      woken_task     <= 4'(o_task_n);
      switch_request <= o_sw_n;
      last           <= o_last_n;
    end
  end

  // Next state and list commands
  always_comb begin
    list_op_t act_op, ovf_op;
    state_next      = state;
    idx_next        = idx;
    tick_count_next = tick_count;
    next_wake_next  = next_wake;
    act_sel_next    = act_sel;
    found0_next     = found0;
    found1_next     = found1;
    sw_next         = sw;
    pend_v_next     = pend_v;
    pend_id_next    = pend_id;
    cur_id_next     = cur_id;
    wake_next       = wake;
    ovf_next        = ovf;
    run_prio_next   = run_prio;
    mem_we          = 1'b0;
    rd_addr         = head_a;
    op0             = LIST_NOP;
    op1             = LIST_NOP;
    act_op          = LIST_NOP;
    ovf_op          = LIST_NOP;
    l_pos           = idx[IDX_W-1:0];
    l_id            = cur_id;
    out_load        = 1'b0;
    o_valid_n       = 1'b0;
    o_task_n        = '0;
    o_sw_n          = 1'b0;
    o_last_n        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_DELAY) begin
            if (id_ok) begin
              mem_we      = 1'b1;
              cur_id_next = IDX_W'(task_id);
              wake_next   = sum[31:0];
              ovf_next    = sum[32];
              idx_next    = '0;
              found0_next = 1'b0;
              found1_next = 1'b0;
              state_next  = ST_DROP;
            end
          end else begin
            run_prio_next   = running_prio;
            sw_next         = 1'b0;
            pend_v_next     = 1'b0;
            tick_count_next = tick_count + 32'd1;
            state_next      = ST_TICK;
          end
        end
      end

      // Remove the task from whichever list holds it
      ST_DROP: begin
        if (!found0 && idx < cnt0 && rd0 == cur_id) begin
          op0         = LIST_DROP;
          found0_next = 1'b1;
        end
        if (!found1 && idx < cnt1 && rd1 == cur_id) begin
          op1         = LIST_DROP;
          found1_next = 1'b1;
        end
        if (idx == CNT_W'(MAX_TASKS - 1)) begin
          idx_next   = '0;
          state_next = ST_INS_RD;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      // Walk the target list for the first later wake time
      ST_INS_RD: begin
        rd_addr = rd_t;
        if (idx >= cnt_t) begin
          if (cnt_t < CNT_W'(MAX_TASKS)) begin
            if (ovf) begin
              ovf_op = LIST_INS;
            end else begin
              act_op = LIST_INS;
            end
          end
          if (!ovf && wake < next_wake) begin
            next_wake_next = wake;
          end
          state_next = ST_IDLE;
        end else begin
          state_next = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        if (wt_q > wake) begin
          if (ovf) begin
            ovf_op = LIST_INS;
          end else begin
            act_op = LIST_INS;
          end
          if (!ovf && wake < next_wake) begin
            next_wake_next = wake;
          end
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_INS_RD;
        end
      end

      // Swap lists on counter wrap
      ST_TICK: begin
        if (tick_count == '0) begin
          act_sel_next = !act_sel;
          rd_addr      = act_sel ? head0 : head1;
          if ((act_sel ? cnt0 : cnt1) == '0) begin
            next_wake_next = NO_WAKE;
            state_next     = ST_CHECK;
          end else begin
            state_next = ST_RELOAD;
          end
        end else begin
          state_next = ST_CHECK;
        end
      end

      ST_RELOAD: begin
        next_wake_next = wt_q;
        state_next     = ST_CHECK;
      end

      ST_CHECK: begin
        state_next = (tick_count >= next_wake) ? ST_POP_RD : ST_FINISH;
      end

      // Pop expired heads, one per pass
      ST_POP_RD: begin
        if (cnt_a == '0) begin
          next_wake_next = NO_WAKE;
          state_next     = ST_FINISH;
        end else begin
          state_next = ST_POP_CMP;
        end
      end

      ST_POP_CMP: begin
        if (tick_count < wt_q) begin
          next_wake_next = wt_q;
          state_next     = ST_FINISH;
        end else if (!pend_v || out_free) begin
          if (pend_v) begin
            out_load  = 1'b1;
            o_valid_n = 1'b1;
            o_task_n  = pend_id;
          end
          act_op       = LIST_DROP;
          l_pos        = '0;
          pend_v_next  = 1'b1;
          pend_id_next = head_a;
          if (run_prio > pr_q) begin
            sw_next = 1'b1;
          end
          state_next = ST_POP_RD;
        end
      end

      // Send the closing word of the tick
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_valid_n  = pend_v;
          o_task_n   = pend_v ? pend_id : '0;
          o_sw_n     = sw || time_slicing;
          o_last_n   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Map active/overflow commands onto the physical lists
    if (state != ST_DROP) begin
      op0 = act_sel ? ovf_op : act_op;
      op1 = act_sel ? act_op : ovf_op;
    end
  end

endmodule

// ===== src/tdq_chk.sv =====
// Port-level checks of the tick delay queue, bound to the top level.
// Depends only on the top level's ports.
module tdq_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       kind,
  input logic       out_valid,
  input logic       out_stall,
  input logic       woken_valid,
  input logic [3:0] woken_task,
  input logic       switch_request,
  input logic       last
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(woken_task) && $stable(last))
    else $error("stalled result word changed");

  // An empty result closes its tick
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !woken_valid |-> last && woken_task == 4'd0)
    else $error("empty result not final");

  // Busy while more results of a tick follow
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken mid-tick");

  // Switch request only on a final word
  a_sw_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && switch_request |-> last)
    else $error("switch request before last");

  // A tick always occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !kind |=> in_stall)
    else $error("tick not processed");

endmodule

bind tick_delay_queue tdq_chk u_tdq_chk (.*);

// ===== verif/tb_tick_delay_queue.sv =====
// Self-checking testbench of tick_delay_queue: directed table then random words,
// checked against an in-bench predictor of the tick and delay queues.
// Depends on src/tdq_pkg.sv and src/tick_delay_queue.sv.
module tb_tick_delay_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import tdq_pkg::*;

  localparam int NTASK = 16;
  localparam int N_RANDOM = 280;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 60;

  typedef struct {
    logic        kind;
    logic [3:0]  id;
    logic [4:0]  prio;
    logic [31:0] delay;
    logic [4:0]  running;
    bit          fixed;
    logic        f_woken;
    logic [3:0]  f_task;
    logic        f_sw;
  } stim_row_t;

  typedef struct {
    logic       woken;
    logic [3:0] task_id;
    logic       sw;
    logic       last;
  } wake_word_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        kind = KIND_TICK;
  logic [3:0]  task_id = 0;
  logic [4:0]  task_prio = 0;
  logic [31:0] delay_ticks = 0;
  logic [4:0]  running_prio = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        woken_valid;
  logic [3:0]  woken_task;
  logic        switch_request;
  logic        last;

  tick_delay_queue i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .task_id(task_id),
    .task_prio(task_prio), .delay_ticks(delay_ticks), .running_prio(running_prio),
    .out_valid(out_valid), .out_stall(out_stall), .woken_valid(woken_valid),
    .woken_task(woken_task), .switch_request(switch_request), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor state
  bit          slicing;
  logic [31:0] now_tick;
  logic [31:0] soonest;
  logic [31:0] wake_at [NTASK];
  logic [4:0]  prio_of [NTASK];
  logic [3:0]  due_list[$];
  logic [3:0]  late_list[$];

  wake_word_t  wake_words[$];
  bit          failed = 0;
  int          snd_idle = 0;
  int          rcv_stall = 0;
  int          idle_cycles = 0;

  // Remove a task from an ordered list if present
  function automatic void drop_task(ref logic [3:0] q[$], input logic [3:0] id);
    for (int i = 0; i < q.size(); i++) begin
      if (q[i] == id) begin
        q.delete(i);
        return;
      end
    end
  endfunction

  // Insert behind every task with an equal or earlier wake time
  function automatic void insert_task(ref logic [3:0] q[$], input logic [3:0] id);
    int pos;
    pos = 0;
    while (pos < q.size() && wake_at[q[pos]] <= wake_at[id]) pos++;
    q.insert(pos, id);
  endfunction

  // Advance the queue model by one word and append the result words it causes
  task automatic predict_wakeups(input stim_row_t r, input bit keep);
    logic [31:0] wake;
    logic [3:0]  tmp[$];
    logic [3:0]  woken[$];
    logic [3:0]  h;
    bit          sw;
    sw = 0;
    if (r.kind == KIND_DELAY) begin
      wake = now_tick + r.delay;
      drop_task(due_list, r.id);
      drop_task(late_list, r.id);
      wake_at[r.id] = wake;
      prio_of[r.id] = r.prio;
      if (wake < now_tick) insert_task(late_list, r.id);
      else begin
        insert_task(due_list, r.id);
        if (wake < soonest) soonest = wake;
      end
    end else begin
      now_tick = now_tick + 1;
      // swap lists on counter wrap
      if (now_tick == 0) begin
        tmp = due_list;
        due_list = late_list;
        late_list = tmp;
        soonest = due_list.size() ? wake_at[due_list[0]] : NO_WAKE;
      end
      if (now_tick >= soonest) begin
        forever begin
          if (due_list.size() == 0) begin
            soonest = NO_WAKE;
            break;
          end
          h = due_list[0];
          if (now_tick < wake_at[h]) begin
            soonest = wake_at[h];
            break;
          end
          void'(due_list.pop_front());
          if (r.running > prio_of[h]) sw = 1;
          woken.push_back(h);
        end
      end
      if (slicing) sw = 1;
      if (keep) begin
        if (woken.size() == 0) wake_words.push_back('{1'b0, 4'd0, sw, 1'b1});
        for (int k = 0; k < woken.size(); k++)
          wake_words.push_back('{1'b1, woken[k], sw && (k == woken.size() - 1),
                                 k == woken.size() - 1});
      end
    end
  endtask

  // Offer one word, with random idle gaps, and hold it until accepted
  task automatic send_word(input stim_row_t r);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= r.kind;
    task_id <= r.id;
    task_prio <= r.prio;
    delay_ticks <= r.delay;
    running_prio <= r.running;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_wakeups(r, !r.fixed);
    if (r.fixed && r.kind == KIND_TICK)
      wake_words.push_back('{r.f_woken, r.f_task, r.f_sw, 1'b1});
  endtask

  // Wait until the block drains, then write the slicing register
  task automatic write_slicing(input bit v);
    in_valid <= 0;
    @(posedge clk);
    while (wake_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    slicing = v;
  endtask

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int sel;
    r.kind = ($urandom_range(99) < 45) ? KIND_TICK : KIND_DELAY;
    r.id = 4'($urandom_range(NTASK - 1));
    r.prio = 5'($urandom_range(31));
    r.running = 5'($urandom_range(31));
    sel = $urandom_range(99);
    if (sel < 70) r.delay = 32'($urandom_range(12));
    else if (sel < 85) r.delay = 32'($urandom_range(200));
    else r.delay = 32'($urandom);
    r.fixed = 0;
    r.f_woken = 0;
    r.f_task = 0;
    r.f_sw = 0;
    return r;
  endfunction

  // Check result words and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (wake_words.size() == 0) begin
          $display("%0t: unexpected word woken=%b task=%0d sw=%b last=%b", $realtime,
                   woken_valid, woken_task, switch_request, last);
          failed = 1;
        end else begin
          if (woken_valid !== wake_words[0].woken ||
              woken_task !== wake_words[0].task_id ||
              switch_request !== wake_words[0].sw || last !== wake_words[0].last) begin
            $display("%0t: expected woken=%b task=%0d sw=%b last=%b", $realtime,
                     wake_words[0].woken, wake_words[0].task_id, wake_words[0].sw,
                     wake_words[0].last);
            $display("%0t: actual   woken=%b task=%0d sw=%b last=%b", $realtime,
                     woken_valid, woken_task, switch_request, last);
            failed = 1;
          end
          void'(wake_words.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  stim_row_t table_rows[$];

  initial begin
    slicing = 0;
    now_tick = 0;
    soonest = NO_WAKE;
    for (int i = 0; i < NTASK; i++) begin
      wake_at[i] = 0;
      prio_of[i] = 0;
    end
    // kind, id, prio, delay, running, fixed, woken, task, sw
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd0,  1, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd0,  5'd0,  32'd0,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd31, 1, 1, 4'd0, 1});
    table_rows.push_back('{KIND_DELAY, 4'd15, 5'd31, 32'hFFFF_FFFF, 5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd3,  5'd5,  32'd2,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd4,  5'd5,  32'd2,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd5,  5'd0,  32'd2,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd3,  5'd5,  32'd3,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd7,  5'd9,  32'hAAAA_5555, 5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd8,  5'd9,  32'h5555_AAAA, 5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd31, 0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd5,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd8,  5'd1,  32'd1,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_DELAY, 4'd15, 5'd2,  32'd0,         5'd0,  0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd31, 0, 0, 4'd0, 0});
    table_rows.push_back('{KIND_TICK,  4'd0,  5'd0,  32'd0,         5'd0,  0, 0, 4'd0, 0});

    // hold reset, then set the register before any word
    repeat (6) @(posedge clk);
    rst <= 0;
    write_slicing(0);
    foreach (table_rows[i]) send_word(table_rows[i]);

    // random phases over idling mixes and both slicing settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 81; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 81; end
        default: begin snd_idle = 26; rcv_stall = 26; end
      endcase
      write_slicing(ph % 2);
      for (int n = 0; n < N_RANDOM / 4; n++) send_word(rand_row());
    end

    in_valid <= 0;
    @(posedge clk);
    while (wake_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
src/tdq_pkg.sv
src/tdq_list.sv
src/tick_delay_queue.sv
src/tdq_chk.sv
verif/tb_tick_delay_queue.sv
